// ----- hdl/clts_pkg.sv -----
package clts_pkg;

  // Field widths of the two channels.
  localparam int unsigned CH_W    = 8;
  localparam int unsigned SCORE_W = 4;
  localparam int unsigned HITS_W  = 7;
  localparam int unsigned TOOL_W  = 4;

  // Window depth default and the byte counter.
  localparam int unsigned MATCH_WINDOW_DEF = 19;
  localparam int unsigned SEEN_W           = 5;
  localparam logic [SEEN_W-1:0] SEEN_MAX   = 5'd31;

  // Pattern table geometry.
  localparam int unsigned PAT_COUNT   = 37;
  localparam int unsigned PAT_MAX_LEN = 19;
  localparam int unsigned PAT_W       = PAT_MAX_LEN * CH_W;
  localparam int unsigned TOOL_COUNT  = 11;

  // Pattern indices used by the rules.
  localparam int unsigned PI_SHELL_A   = 11;
  localparam int unsigned PI_SHELL_B   = 12;
  localparam int unsigned PI_ENCCMD    = 13;
  localparam int unsigned PI_ENC       = 14;
  localparam int unsigned PI_NOP       = 15;
  localparam int unsigned PI_HIDDEN    = 16;
  localparam int unsigned PI_DEVTCP    = 17;
  localparam int unsigned PI_NC        = 18;
  localparam int unsigned PI_DASH_E    = 19;
  localparam int unsigned PI_BASH_I    = 20;
  localparam int unsigned PI_REDIR     = 21;
  localparam int unsigned PI_SHADOW    = 22;
  localparam int unsigned PI_PASSWD    = 23;
  localparam int unsigned PI_CAT       = 24;
  localparam int unsigned PI_CP        = 25;
  localparam int unsigned PI_CHMOD     = 26;
  localparam int unsigned PI_PLUS_S    = 27;
  localparam int unsigned PI_4755      = 28;
  localparam int unsigned PI_B64       = 29;
  localparam int unsigned PI_DASH_D    = 30;
  localparam int unsigned PI_DECODE    = 31;
  localparam int unsigned PI_CURL      = 32;
  localparam int unsigned PI_WGET      = 33;
  localparam int unsigned PI_PIPE      = 34;
  localparam int unsigned PI_BASH      = 35;
  localparam int unsigned PI_SH        = 36;

  // Rule bit positions in the hit mask.
  localparam int unsigned RB_B64     = 0;
  localparam int unsigned RB_DLEXEC  = 1;
  localparam int unsigned RB_TOOL    = 2;
  localparam int unsigned RB_OBFUSC  = 3;
  localparam int unsigned RB_REVSH   = 4;
  localparam int unsigned RB_CRED    = 5;
  localparam int unsigned RB_SUID    = 6;

  // Rule weights in tenths, and the saturation limit of the score.
  localparam int unsigned SUM_W = 6;
  localparam logic [SUM_W-1:0] W_B64    = 6'd3;
  localparam logic [SUM_W-1:0] W_DLEXEC = 6'd5;
  localparam logic [SUM_W-1:0] W_TOOL   = 6'd7;
  localparam logic [SUM_W-1:0] W_OBFUSC = 6'd6;
  localparam logic [SUM_W-1:0] W_REVSH  = 6'd8;
  localparam logic [SUM_W-1:0] W_CRED   = 6'd4;
  localparam logic [SUM_W-1:0] W_SUID   = 6'd6;
  localparam logic [SUM_W-1:0] SCORE_MAX = 6'd10;

  // Pattern text, right aligned: byte j from the bottom is compared with the
  // byte received j positions before the newest one. Entries 0 to 10 are the
  // tool names in priority order.
  localparam logic [PAT_W-1:0] PAT_TEXT [PAT_COUNT] = '{
    152'h6d696d696b61747a,
    152'h6d65746572707265746572,
    152'h636f62616c74737472696b65,
    152'h656d70697265,
    152'h626c6f6f64686f756e64,
    152'h727562657573,
    152'h6c617a61676e65,
    152'h637261636b6d617065786563,
    152'h6e636174,
    152'h6e6574636174,
    152'h6e632e747261646974696f6e616c,
    152'h706f7765727368656c6c,
    152'h70777368,
    152'h2d656e636f646564636f6d6d616e64,
    152'h2d656e6320,
    152'h2d6e6f70,
    152'h2d77696e646f777374796c652068696464656e,
    152'h2f6465762f7463702f,
    152'h6e6320,
    152'h2d65,
    152'h62617368202d69,
    152'h3e26,
    152'h2f6574632f736861646f77,
    152'h2f6574632f706173737764,
    152'h636174,
    152'h6370,
    152'h63686d6f64,
    152'h2b73,
    152'h34373535,
    152'h626173653634,
    152'h2d64,
    152'h2d2d6465636f6465,
    152'h6375726c,
    152'h77676574,
    152'h7c,
    152'h62617368,
    152'h7368
  };

  localparam logic [SEEN_W-1:0] PAT_LEN [PAT_COUNT] = '{
    5'd8,  5'd11, 5'd12, 5'd6,  5'd10, 5'd6,  5'd7,  5'd12, 5'd4,  5'd6,
    5'd14, 5'd10, 5'd4,  5'd15, 5'd5,  5'd4,  5'd19, 5'd9,  5'd3,  5'd2,
    5'd7,  5'd2,  5'd11, 5'd11, 5'd3,  5'd2,  5'd5,  5'd2,  5'd4,  5'd6,
    5'd2,  5'd8,  5'd4,  5'd4,  5'd1,  5'd4,  5'd2
  };

  // Set where the pattern is compared against the lower-cased byte.
  localparam logic [PAT_COUNT-1:0] PAT_LOWER = 37'h0_1fff_ffff;

  // Control from the top level to the matcher for one processed transaction.
  typedef struct packed {
    logic step;
    logic has_byte;
    logic line_end;
  } clts_ctrl_t;

  // One scored line.
  typedef struct packed {
    logic [SCORE_W-1:0] score_tenths;
    logic [HITS_W-1:0]  rule_hits;
    logic [TOOL_W-1:0]  tool_index;
  } clts_result_t;

  // Only the capital letters change.
  function automatic logic [CH_W-1:0] to_lower(input logic [CH_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

endpackage

// ----- hdl/clts_in_if.sv -----
interface clts_in_if import clts_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            no_byte;
  logic            last;

  modport source (output valid, output ch, output no_byte, output last, input ready);
  modport sink (input valid, input ch, input no_byte, input last, output ready);
endinterface

// ----- hdl/clts_out_if.sv -----
interface clts_out_if import clts_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score_tenths;
  logic [HITS_W-1:0]  rule_hits;
  logic [TOOL_W-1:0]  tool_index;

  modport source (output valid, output score_tenths, output rule_hits, output tool_index,
                  input ready);
  modport sink (input valid, input score_tenths, input rule_hits, input tool_index,
                output ready);
endinterface

// ----- hdl/clts_matcher.sv -----
module clts_matcher import clts_pkg::*; #(
  parameter int unsigned MATCH_WINDOW = MATCH_WINDOW_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clts_ctrl_t           ctrl_i,
  input  logic [CH_W-1:0]      ch_i,
  output logic [PAT_COUNT-1:0] flags_o
);

  logic [CH_W-1:0]      win_q [MATCH_WINDOW];
  logic [CH_W-1:0]      win_d [MATCH_WINDOW];
  logic [SEEN_W-1:0]    seen_q;
  logic [SEEN_W-1:0]    seen_d;
  logic [PAT_COUNT-1:0] flags_q;
  logic [PAT_COUNT-1:0] hit;

  // Window with the new byte shifted in, and the saturating byte count.
  always_comb begin
    win_d[0] = ch_i;
    for (int k = 1; k < MATCH_WINDOW; k++) begin
      win_d[k] = win_q[k-1];
    end
    seen_d = (seen_q == SEEN_MAX) ? seen_q : seen_q + 5'd1;
  end

  // Every pattern is compared against the window ending at the new byte. A
  // pattern only counts once the line holds at least its length in bytes.
  always_comb begin
    for (int p = 0; p < PAT_COUNT; p++) begin
      hit[p] = (int'(PAT_LEN[p]) <= MATCH_WINDOW) && (PAT_LEN[p] <= seen_d);
      for (int j = 0; j < PAT_MAX_LEN; j++) begin
        if (j < int'(PAT_LEN[p])) begin
          if ((PAT_LOWER[p] ? to_lower(win_d[j]) : win_d[j]) != PAT_TEXT[p][j*CH_W +: CH_W]) begin
            hit[p] = 1'b0;
          end
        end
      end
    end
  end

  // Flags of the line including the current byte.
  assign flags_o = flags_q | (ctrl_i.has_byte ? hit : '0);

  // Line state: cleared at the end of a line, advanced on every byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MATCH_WINDOW; k++) begin
        win_q[k] <= '0;
      end
      seen_q  <= '0;
      flags_q <= '0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.line_end) begin
        for (int k = 0; k < MATCH_WINDOW; k++) begin
          win_q[k] <= '0;
        end
        seen_q  <= '0;
        flags_q <= '0;
      end else if (ctrl_i.has_byte) begin
        win_q   <= win_d;
        seen_q  <= seen_d;
        flags_q <= flags_o;
      end
    end
  end

endmodule

// ----- hdl/clts_rules.sv -----
module clts_rules import clts_pkg::*; (
  input  logic [PAT_COUNT-1:0] flags_i,
  output clts_result_t         res_o
);

  logic [HITS_W-1:0] hits;
  logic [TOOL_W-1:0] tool;
  logic [SUM_W-1:0]  sum;

  // First tool name in table order wins.
  always_comb begin
    tool = '0;
    for (int i = TOOL_COUNT - 1; i >= 0; i--) begin
      if (flags_i[i]) begin
        tool = TOOL_W'(i + 1);
      end
    end
  end

  // The seven rules.
  always_comb begin
    hits = '0;
    hits[RB_B64]    = flags_i[PI_B64] && (flags_i[PI_DASH_D] || flags_i[PI_DECODE]);
    hits[RB_DLEXEC] = (flags_i[PI_CURL] || flags_i[PI_WGET]) && flags_i[PI_PIPE]
                      && (flags_i[PI_BASH] || flags_i[PI_SH]);
    hits[RB_TOOL]   = (tool != '0);
    hits[RB_OBFUSC] = (flags_i[PI_SHELL_A] || flags_i[PI_SHELL_B])
                      && (flags_i[PI_ENCCMD] || flags_i[PI_ENC] || flags_i[PI_NOP]
                          || flags_i[PI_HIDDEN]);
    hits[RB_REVSH]  = flags_i[PI_DEVTCP] || (flags_i[PI_NC] && flags_i[PI_DASH_E])
                      || (flags_i[PI_BASH_I] && flags_i[PI_REDIR]);
    hits[RB_CRED]   = (flags_i[PI_SHADOW] || flags_i[PI_PASSWD])
                      && (flags_i[PI_CAT] || flags_i[PI_CP]);
    hits[RB_SUID]   = flags_i[PI_CHMOD] && (flags_i[PI_PLUS_S] || flags_i[PI_4755]);
  end

  // Weighted sum, saturated.
  assign sum = (hits[RB_B64]    ? W_B64    : '0) + (hits[RB_DLEXEC] ? W_DLEXEC : '0)
             + (hits[RB_TOOL]   ? W_TOOL   : '0) + (hits[RB_OBFUSC] ? W_OBFUSC : '0)
             + (hits[RB_REVSH]  ? W_REVSH  : '0) + (hits[RB_CRED]   ? W_CRED   : '0)
             + (hits[RB_SUID]   ? W_SUID   : '0);

  assign res_o.score_tenths = (sum > SCORE_MAX) ? SCORE_MAX[SCORE_W-1:0] : sum[SCORE_W-1:0];
  assign res_o.rule_hits    = hits;
  assign res_o.tool_index   = tool;

endmodule

// ----- hdl/command_line_threat_scorer.sv -----
// Scores a command line streamed in at most one byte per transaction, one
// transaction per clock cycle. Each accepted byte is held in an input register
// and compared from there, in a single pass, against every fixed pattern over
// the window of recent bytes; the seen flags of the line are updated when the
// byte is processed. On the transaction marked last the flags are combined
// into the rule mask, tool index and saturated score, which are written to the
// output register when that transaction is processed. Transactions that are
// not last give no result. A pending result does not stop bytes from flowing;
// only a second last transaction that meets an untaken result waits for the
// output register.
module command_line_threat_scorer import clts_pkg::*; #(
  parameter int unsigned MATCH_WINDOW = MATCH_WINDOW_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  clts_in_if.sink    in_i,
  clts_out_if.source out_o
);

  logic                 in_valid_q;
  logic [CH_W-1:0]      ch_q;
  logic                 no_byte_q;
  logic                 last_q;
  logic                 out_valid_q;
  clts_result_t         res_q;
  clts_result_t         res;
  clts_ctrl_t           ctrl;
  logic [PAT_COUNT-1:0] line_flags;
  logic                 out_free;
  logic                 proc;
  logic                 in_ready;

  // Handshake: a held item is processed unless it must write a busy output.
  assign out_free = !out_valid_q || out_o.ready;
  assign proc     = in_valid_q && (!last_q || out_free);
  assign in_ready = !in_valid_q || proc;

  assign ctrl.step     = proc;
  assign ctrl.has_byte = !no_byte_q;
  assign ctrl.line_end = last_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      ch_q      <= in_i.ch;
      no_byte_q <= in_i.no_byte;
      last_q    <= in_i.last;
    end
  end

  clts_matcher #(
    .MATCH_WINDOW (MATCH_WINDOW)
  ) u_matcher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .ch_i    (ch_q),
    .flags_o (line_flags)
  );

  clts_rules u_rules (
    .flags_i (line_flags),
    .res_o   (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      res_q <= res;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.score_tenths = res_q.score_tenths;
  assign out_o.rule_hits    = res_q.rule_hits;
  assign out_o.tool_index   = res_q.tool_index;

  // A finished line always lands in the result register.
  a_line_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && last_q |=> out_valid_q)
    else $error("finished line did not reach the result register");

  // A result waiting to be taken is never overwritten.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !(proc && last_q))
    else $error("pending result overwritten");

  // The score stays within its saturation limit.
  a_score_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.score_tenths <= SCORE_MAX[SCORE_W-1:0])
    else $error("score above limit");

  // The tool rule bit agrees with the tool index.
  a_tool_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.rule_hits[RB_TOOL] == (res_q.tool_index != '0))
    else $error("tool rule bit and tool index disagree");

endmodule
